### design/assert_macros.svh
// assertion macros shared by the core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked with the consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/sbtf_pkg.sv
// package for the sixteen bit two format core
// types, codes and constants shared by all modules
package sbtf_pkg;

    localparam int MemoryWords = 65536;
    localparam int MemAddrBits = $clog2(MemoryWords);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_SUB   = 6'd1;
    localparam logic [5:0] OP_MUL   = 6'd2;
    localparam logic [5:0] OP_DIV   = 6'd3;
    localparam logic [5:0] OP_EQ    = 6'd4;
    localparam logic [5:0] OP_NE    = 6'd5;
    localparam logic [5:0] OP_LOAD  = 6'd15;
    localparam logic [5:0] OP_STORE = 6'd16;
    localparam logic [5:0] OP_HALT  = 6'd63;

    localparam logic [1:0] IOP_JMP = 2'd0;
    localparam logic [1:0] IOP_JEQ = 2'd1;
    localparam logic [1:0] IOP_MOV = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_DECODE,
        ST_LOAD,
        ST_LOAD_WAIT,
        ST_DIV,
        ST_MUL,
        ST_DONE,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture_in;
        logic mem_write_cmd;
        logic fetch;
        logic capture_word;
        logic exec;
        logic load_read;
        logic load_capture;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic mul_finish;
        logic out_load;
    } ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_write;
        logic halted;
        logic is_load;
        logic is_div;
        logic is_mul;
        logic div_last;
    } stat_t;

endpackage

### design/sbtf_if.sv
// valid/ready channel interface
// depends on nothing
interface sbtf_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] word_address;
    logic [15:0] word_data;
    modport source (output valid, command, word_address, word_data, input ready);
    modport sink (input valid, command, word_address, word_data, output ready);
endinterface

interface sbtf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] program_counter;
    logic        halted;
    logic [15:0] executed_word;
    logic [15:0] written_value;
    logic        undefined_opcode;
    logic        divide_by_zero;
    modport source (output valid, program_counter, halted, executed_word, written_value,
        undefined_opcode, divide_by_zero, input ready);
    modport sink (input valid, program_counter, halted, executed_word, written_value,
        undefined_opcode, divide_by_zero, output ready);
endinterface

### design/sbtf_ctrl.sv
// controller state machine of the core
// depends on sbtf_pkg
module sbtf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  sbtf_pkg::stat_t stat,
    output sbtf_pkg::ctrl_t ctrl
);
    import sbtf_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (stat.is_write || stat.halted)
                    state_next = ST_DONE;
                else
                    state_next = ST_FETCH;
            end
            ST_FETCH:      state_next = ST_FETCH_WAIT;
            ST_FETCH_WAIT: state_next = ST_DECODE;
            ST_DECODE:
            begin
                if (stat.is_load)
                    state_next = ST_LOAD;
                else if (stat.is_div)
                    state_next = ST_DIV;
                else if (stat.is_mul)
                    state_next = ST_MUL;
                else
                    state_next = ST_DONE;
            end
            ST_LOAD:      state_next = ST_LOAD_WAIT;
            ST_LOAD_WAIT: state_next = ST_DONE;
            ST_DIV:
                if (stat.div_last)
                    state_next = ST_DONE;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE: state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctrl.capture_in = in_valid;
            end
            ST_WRITE:      ctrl.mem_write_cmd = stat.is_write;
            ST_FETCH:      ctrl.fetch = 1'b1;
            ST_FETCH_WAIT: ctrl.capture_word = 1'b1;
            ST_DECODE:
            begin
                ctrl.exec = !(stat.is_load || stat.is_div || stat.is_mul);
                ctrl.div_start = stat.is_div;
            end
            ST_LOAD:       ctrl.load_read = 1'b1;
            ST_LOAD_WAIT:  ctrl.load_capture = 1'b1;
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                ctrl.div_finish = stat.div_last;
            end
            ST_MUL:        ctrl.mul_finish = 1'b1;
            ST_DONE:       ctrl.out_load = 1'b1;
            ST_OUT:        out_valid = 1'b1;
            default:       ctrl = '0;
        endcase
    end
endmodule

### design/sbtf_datapath.sv
// datapath of the core: memory, registers, alu, multiplier and serial divider
// depends on sbtf_pkg
module sbtf_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  sbtf_pkg::ctrl_t ctrl,
    output sbtf_pkg::stat_t stat,
    input  logic            in_command,
    input  logic [15:0]     in_word_address,
    input  logic [15:0]     in_word_data,
    output logic [15:0]     program_counter,
    output logic            halted,
    output logic [15:0]     executed_word,
    output logic [15:0]     written_value,
    output logic            undefined_opcode,
    output logic            divide_by_zero
);
    import sbtf_pkg::*;

    logic [15:0] mem [MemoryWords];
    logic [15:0] mem_rdata_reg;

    logic [15:0] regs_reg [8];
    logic [15:0] pc_reg;
    logic        halted_reg;
    logic        cmd_reg;
    logic [15:0] addr_reg, data_reg;
    logic [15:0] word_reg;
    logic [15:0] wval_reg;
    logic        undef_reg, dz_reg;
    logic [15:0] mul_reg;

    // divider state
    logic [15:0] quo_reg, rem_reg, dvs_reg;
    logic [4:0]  cnt_reg;

    // decode
    logic        fmt;
    logic [5:0]  opc;
    logic [2:0]  rd, rs, rt, ri;
    logic [1:0]  iopc;
    logic [15:0] x, y, rv, imm, pc_inc;
    assign fmt = word_reg[15];
    assign opc = word_reg[14:9];
    assign rd = word_reg[8:6];
    assign rs = word_reg[5:3];
    assign rt = word_reg[2:0];
    assign iopc = word_reg[14:13];
    assign ri = word_reg[12:10];
    assign imm = {6'd0, word_reg[9:0]};
    assign x = regs_reg[rs];
    assign y = regs_reg[rt];
    assign rv = regs_reg[ri];
    assign pc_inc = pc_reg + 16'd1;

    assign stat.is_write = (cmd_reg == CMD_WRITE);
    assign stat.halted = halted_reg;
    assign stat.is_load = !fmt && opc == OP_LOAD;
    assign stat.is_div = !fmt && opc == OP_DIV && y != 16'd0;
    assign stat.is_mul = !fmt && opc == OP_MUL;
    assign stat.div_last = (cnt_reg == 5'd15);

    // memory address select
    logic [MemAddrBits-1:0] raddr;
    always_comb
    begin
        if (ctrl.fetch)
            raddr = pc_reg[MemAddrBits-1:0];
        else
            raddr = x[MemAddrBits-1:0];
    end

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_write_cmd)
            mem[addr_reg[MemAddrBits-1:0]] <= data_reg;
        else if (ctrl.exec && !fmt && opc == OP_STORE)
            mem[x[MemAddrBits-1:0]] <= y;
        if (ctrl.fetch || ctrl.load_read)
            mem_rdata_reg <= mem[raddr];
    end

    // payload registers and divider
    logic [16:0] rem_shift;
    always_comb
        rem_shift = {rem_reg, quo_reg[15]} - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.capture_in)
        begin
            cmd_reg <= in_command;
            addr_reg <= in_word_address;
            data_reg <= in_word_data;
            word_reg <= 16'd0;
            wval_reg <= (in_command == CMD_WRITE) ? in_word_data : 16'd0;
            undef_reg <= 1'b0;
            dz_reg <= 1'b0;
        end
        if (ctrl.capture_word)
            word_reg <= mem_rdata_reg;
        if (ctrl.div_start)
        begin
            quo_reg <= x;
            rem_reg <= 16'd0;
            dvs_reg <= y;
        end
        else if (ctrl.div_step)
        begin
            if (!rem_shift[16])
            begin
                rem_reg <= rem_shift[15:0];
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[14:0], quo_reg[15]};
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (ctrl.exec)
        begin
            if (!fmt)
            begin
                case (opc)
                    OP_ADD:   wval_reg <= x + y;
                    OP_SUB:   wval_reg <= x - y;
                    OP_DIV:   wval_reg <= 16'hFFFF;
                    OP_EQ:    wval_reg <= {15'd0, x == y};
                    OP_NE:    wval_reg <= {15'd0, x != y};
                    OP_STORE: wval_reg <= y;
                    OP_HALT:  wval_reg <= 16'd0;
                    default:  undef_reg <= 1'b1;
                endcase
                dz_reg <= (opc == OP_DIV);
            end
            else
            begin
                if (iopc == IOP_MOV)
                    wval_reg <= imm;
                undef_reg <= (iopc == 2'd2);
            end
        end
        if (ctrl.div_finish)
            wval_reg <= rem_shift[16] ? {quo_reg[14:0], 1'b0} : {quo_reg[14:0], 1'b1};
        if (ctrl.load_capture)
            wval_reg <= mem_rdata_reg;
        if (ctrl.mul_finish)
            wval_reg <= mul_reg;
    end

    // multiplier with registered product
    always_ff @(posedge clk)
        mul_reg <= x * y;

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= 16'd1;
            halted_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                regs_reg[i] <= 16'd0;
        end
        else
        begin
            if (ctrl.exec)
            begin
                if (!fmt)
                begin
                    pc_reg <= pc_inc;
                    case (opc)
                        OP_ADD:  regs_reg[rd] <= x + y;
                        OP_SUB:  regs_reg[rd] <= x - y;
                        OP_DIV:  regs_reg[rd] <= 16'hFFFF;
                        OP_EQ:   regs_reg[rd] <= {15'd0, x == y};
                        OP_NE:   regs_reg[rd] <= {15'd0, x != y};
                        OP_HALT:
                            if (regs_reg[0] == 16'd0)
                                halted_reg <= 1'b1;
                        default: ;
                    endcase
                end
                else
                begin
                    case (iopc)
                        IOP_JMP: pc_reg <= imm;
                        IOP_JEQ: pc_reg <= (rv == 16'd1) ? imm : pc_inc;
                        IOP_MOV:
                        begin
                            regs_reg[ri] <= imm;
                            pc_reg <= pc_inc;
                        end
                        default: pc_reg <= pc_inc;
                    endcase
                end
            end
            if (ctrl.div_finish)
            begin
                regs_reg[rd] <= rem_shift[16] ? {quo_reg[14:0], 1'b0}
                                              : {quo_reg[14:0], 1'b1};
                pc_reg <= pc_inc;
            end
            if (ctrl.load_capture)
            begin
                regs_reg[rd] <= mem_rdata_reg;
                pc_reg <= pc_inc;
            end
            if (ctrl.mul_finish)
            begin
                regs_reg[rd] <= mul_reg;
                pc_reg <= pc_inc;
            end
        end
    end

    // divider step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 5'd0;
        else if (ctrl.div_start)
            cnt_reg <= 5'd0;
        else if (ctrl.div_step)
            cnt_reg <= cnt_reg + 5'd1;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            program_counter <= pc_reg;
            halted <= halted_reg;
            executed_word <= word_reg;
            written_value <= wval_reg;
            undefined_opcode <= undef_reg;
            divide_by_zero <= dz_reg;
        end
    end
endmodule

### design/sixteen_bit_two_format_cpu_core_unit.sv
// channel    | dir | payload
// in_ch      | in  | command, word_address, word_data
// out_ch     | out | program_counter, halted, executed_word, written_value, flags
// one transaction in flight at a time; the next is taken after the result is taken
// write word passes write, done and out; a step adds fetch, fetch wait and decode unless halted
// load adds load and load wait; multiply adds mul; divide stays in div, one-bit-a-cycle restoring divider
// reset clears pc to 1, registers to zero and the halt flag; memory is not cleared
// output stall holds the result and blocks new input
`include "assert_macros.svh"

module sixteen_bit_two_format_cpu_core_unit (
    input logic clk,
    input logic rst_n,
    sbtf_in_if.sink    in_ch,
    sbtf_out_if.source out_ch
);
    import sbtf_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    sbtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    sbtf_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .stat             (stat),
        .in_command       (in_ch.command),
        .in_word_address  (in_ch.word_address),
        .in_word_data     (in_ch.word_data),
        .program_counter  (out_ch.program_counter),
        .halted           (out_ch.halted),
        .executed_word    (out_ch.executed_word),
        .written_value    (out_ch.written_value),
        .undefined_opcode (out_ch.undefined_opcode),
        .divide_by_zero   (out_ch.divide_by_zero)
    );

    // checks
    `ASSERT_IMPL(a_excl, in_ch.ready, !out_ch.valid)
    `ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, !in_ch.ready)
    `ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({ctrl.exec, ctrl.div_finish, ctrl.load_capture,
        ctrl.mul_finish}))
endmodule
